// ===== rtl/triple_hash_counter_macros.svh =====
// assertion macros for the triple hash counter checker
`ifndef TRIPLE_HASH_COUNTER_MACROS_SVH
`define TRIPLE_HASH_COUNTER_MACROS_SVH

// implication checked on every edge outside reset
`define THC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication outside reset
`define THC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/thc_pkg.sv =====
// ----------------------------------------------------------------------------
// thc_pkg
// shared constants, types and hash function of the triple hash counter
// ----------------------------------------------------------------------------
package thc_pkg;

    localparam int unsigned BUCKETS = 256;
    localparam int unsigned ENTRIES = 4096;
    localparam int unsigned BKT_W   = $clog2(BUCKETS);
    localparam int unsigned IDX_W   = $clog2(ENTRIES);
    localparam int unsigned FILL_W  = $clog2(ENTRIES + 1);
    localparam int unsigned KEY_W   = 24;
    localparam int unsigned CNT_W   = 32;
    localparam int unsigned QDEPTH  = 2;

    localparam logic [31:0] HASH_MUL = 32'h983F69B1;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_NOFILL = 2'd2;
    localparam logic [1:0] ST_UNUSED = 2'd3;

    // classified request between front and back
    typedef struct packed {
        logic [1:0]       op;
        logic [KEY_W-1:0] key;
        logic [BKT_W-1:0] bucket;
        logic [11:0]      index;
    } req_t;

    // bucket number from bits 19:12 of the hashed key product
    function automatic logic [BKT_W-1:0] bucket_of(input logic [31:0] product);
        logic [11:0] h;
        h = product[23:12];
        return BKT_W'(h % 12'(BUCKETS));
    endfunction

endpackage

// ===== rtl/triple_hash_counter.sv =====
// ----------------------------------------------------------------------------
// triple_hash_counter
// counts byte triples in a chained hash table held in block memory
// ----------------------------------------------------------------------------
// channel | dir | contents
// s_axis  | in  | op, key bytes, read index
// m_axis  | out | status, was_new, distinct count, key, count
// per request: an add passes the head lookup, a compare of each chain entry and
// an append when the key is new; a read passes the read state; clear and the unused op go to output.
// entry and bucket head memories have registered reads, one access per cycle;
// the front registers the hash product and queues it; the back takes no request while a result waits.
// reset clears bucket valid bits and the fill level at once, no clearing pass.
// the front queues two hashed requests so input runs ahead of a stalled output.
module triple_hash_counter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // op[1:0], color_i[9:2], color_j[17:10], color_k[25:18], entry_index[37:26]
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0], was_new[2], distinct_count[15:3], out_i[23:16], out_j[31:24],
    // out_k[39:32], out_count[71:40]
    output logic [71:0] m_axis_tdata
);

    logic          q_valid, q_ready;
    thc_pkg::req_t q_req;
    logic [1:0]  st;
    logic        nw;
    logic [12:0] dc;
    logic [23:0] key;
    logic [31:0] cnt;

    thc_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_op(s_axis_tdata[1:0]), .in_key(s_axis_tdata[25:2]),
        .in_index(s_axis_tdata[37:26]),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
    );

    thc_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_status(st), .out_was_new(nw), .out_distinct(dc),
        .out_key(key), .out_count(cnt)
    );

    assign m_axis_tdata = {cnt, key, dc, nw, st};

endmodule

// ===== rtl/thc_ram.sv =====
// ----------------------------------------------------------------------------
// thc_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module thc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read one word and write it when we is high; the read returns the old value
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== rtl/thc_front.sv =====
// ----------------------------------------------------------------------------
// thc_front
// accepts requests, hashes the key in a multiply stage and queues the result
// ----------------------------------------------------------------------------
module thc_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          in_op,
    input  logic [23:0]         in_key,
    input  logic [11:0]         in_index,
    output logic                q_valid,
    input  logic                q_ready,
    output thc_pkg::req_t       q_req
);

    // hash stage registers
    logic        s1_valid_reg;
    logic [31:0] s1_prod_reg;
    logic [1:0]  s1_op_reg;
    logic [23:0] s1_key_reg;
    logic [11:0] s1_index_reg;

    // queue
    thc_pkg::req_t q_mem_reg [thc_pkg::QDEPTH];
    logic [$clog2(thc_pkg::QDEPTH)-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [$clog2(thc_pkg::QDEPTH+1)-1:0] cnt_reg;

    logic [31:0] mix;
    logic        push, pop;
    thc_pkg::req_t push_req;

    assign mix = 32'(in_key[7:0]) + (32'(in_key[15:8]) << 4) + (32'(in_key[23:16]) << 8);

    // one slot in flight plus the queue, so never overrun
    assign in_ready = (32'(cnt_reg) + 32'(s1_valid_reg)) < thc_pkg::QDEPTH;
    assign push = s1_valid_reg;
    assign pop  = q_valid && q_ready;

    always_comb begin
        push_req.op     = s1_op_reg;
        push_req.key    = s1_key_reg;
        push_req.bucket = thc_pkg::bucket_of(s1_prod_reg);
        push_req.index  = s1_index_reg;
    end

    // multiply stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_valid && in_ready;
        end
        s1_prod_reg  <= mix * thc_pkg::HASH_MUL;
        s1_op_reg    <= in_op;
        s1_key_reg   <= in_key;
        s1_index_reg <= in_index;
    end

    // queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
        end
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= push_req;
        end
    end

    assign q_valid = cnt_reg != '0;
    assign q_req   = q_mem_reg[rd_ptr_reg];

endmodule

// ===== rtl/thc_back.sv =====
// ----------------------------------------------------------------------------
// thc_back
// walks the bucket chain in entry memory and updates counts; also serves reads and clears
// ----------------------------------------------------------------------------
module thc_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_ready,
    input  thc_pkg::req_t       q_req,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          out_status,
    output logic                out_was_new,
    output logic [12:0]         out_distinct,
    output logic [23:0]         out_key,
    output logic [31:0]         out_count
);

    localparam int unsigned IW = thc_pkg::IDX_W;
    localparam int unsigned FW = thc_pkg::FILL_W;
    localparam int unsigned NW = IW + 1;
    localparam int unsigned RW = thc_pkg::KEY_W + thc_pkg::CNT_W + NW;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_HEAD   = 6'b000010,
        S_CMP    = 6'b000100,
        S_APPEND = 6'b001000,
        S_READ   = 6'b010000,
        S_OUT    = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    thc_pkg::req_t req_reg;
    logic [FW-1:0] fill_reg;
    logic [thc_pkg::BUCKETS-1:0] bvalid_reg;
    logic [IW-1:0] ptr_reg;
    logic [FW-1:0] steps_reg;

    // result register
    logic        ov_reg;
    logic [1:0]  ost_reg;
    logic        onew_reg;
    logic [23:0] okey_reg;
    logic [31:0] ocnt_reg;

    // entry memory ports
    logic          e_we;
    logic [IW-1:0] e_addr;
    logic [RW-1:0] e_wdata, e_rdata;
    logic [23:0]   r_key;
    logic [31:0]   r_cnt;
    logic [NW-1:0] r_next;

    // bucket head memory ports
    logic                      h_we;
    logic [thc_pkg::BKT_W-1:0] h_addr;
    logic [IW-1:0]             h_wdata, h_rdata;

    logic          accept, have, hit, room, next_ok;
    logic [FW-1:0] steps_inc;
    logic [31:0]   cnt_inc;

    thc_ram #(.WIDTH(RW), .DEPTH(thc_pkg::ENTRIES))
        u_entry_ram (.aclk(aclk), .we(e_we), .addr(e_addr), .wdata(e_wdata), .rdata(e_rdata));

    thc_ram #(.WIDTH(IW), .DEPTH(thc_pkg::BUCKETS))
        u_head_ram (.aclk(aclk), .we(h_we), .addr(h_addr), .wdata(h_wdata), .rdata(h_rdata));

    assign {r_next, r_cnt, r_key} = e_rdata;
    assign q_ready = (state_reg == S_IDLE) && !ov_reg;
    assign accept  = q_valid && q_ready;

    // walk conditions
    assign have      = bvalid_reg[req_reg.bucket];
    assign hit       = (r_key == req_reg.key);
    assign room      = fill_reg < FW'(thc_pkg::ENTRIES);
    assign steps_inc = steps_reg + 1'b1;
    assign next_ok   = r_next[IW] && (FW'(r_next[IW-1:0]) < fill_reg)
                       && (steps_inc < fill_reg);
    assign cnt_inc   = (&r_cnt) ? r_cnt : r_cnt + 32'd1;

    // next state and memory addressing
    always_comb begin
        state_next = state_reg;
        e_we    = 1'b0;
        e_addr  = ptr_reg;
        e_wdata = '0;
        h_we    = 1'b0;
        h_addr  = req_reg.bucket;
        h_wdata = IW'(fill_reg);
        case (state_reg)
            S_IDLE: begin
                h_addr = q_req.bucket;
                e_addr = q_req.index;
                if (accept) begin
                    case (q_req.op)
                        thc_pkg::OP_ADD:  state_next = S_HEAD;
                        thc_pkg::OP_READ: state_next = S_READ;
                        default:          state_next = S_OUT;
                    endcase
                end
            end
            S_HEAD: begin
                e_addr = h_rdata;
                if (have && (FW'(h_rdata) < fill_reg)) begin
                    state_next = S_CMP;
                end else begin
                    state_next = S_APPEND;
                end
            end
            S_CMP: begin
                if (hit) begin
                    e_we    = 1'b1;
                    e_wdata = {r_next, cnt_inc, r_key};
                    state_next = S_OUT;
                end else if (next_ok) begin
                    e_addr = r_next[IW-1:0];
                end else begin
                    state_next = S_APPEND;
                end
            end
            // new entry at the bucket head
            S_APPEND: begin
                e_addr  = IW'(fill_reg);
                e_wdata = {have, h_rdata, 32'd1, req_reg.key};
                e_we    = room;
                h_we    = room;
                state_next = S_OUT;
            end
            S_READ: state_next = S_OUT;
            S_OUT: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // sequencer and table state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            fill_reg   <= '0;
            bvalid_reg <= '0;
            ov_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_valid && out_ready) begin
                ov_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        req_reg  <= q_req;
                        ost_reg  <= thc_pkg::ST_OK;
                        onew_reg <= 1'b0;
                        okey_reg <= (q_req.op == thc_pkg::OP_ADD) ? q_req.key : '0;
                        ocnt_reg <= '0;
                        if (q_req.op == thc_pkg::OP_CLEAR) begin
                            bvalid_reg <= '0;
                            fill_reg   <= '0;
                        end
                    end
                end
                S_HEAD: begin
                    ptr_reg   <= h_rdata;
                    steps_reg <= '0;
                end
                S_CMP: begin
                    if (hit) begin
                        ocnt_reg <= cnt_inc;
                    end else if (next_ok) begin
                        ptr_reg   <= r_next[IW-1:0];
                        steps_reg <= steps_inc;
                    end
                end
                S_APPEND: begin
                    if (room) begin
                        bvalid_reg[req_reg.bucket] <= 1'b1;
                        fill_reg <= fill_reg + 1'b1;
                        onew_reg <= 1'b1;
                        ocnt_reg <= 32'd1;
                    end else begin
                        ost_reg <= thc_pkg::ST_FULL;
                    end
                end
                S_READ: begin
                    if (FW'(req_reg.index) < fill_reg) begin
                        okey_reg <= r_key;
                        ocnt_reg <= r_cnt;
                    end else begin
                        ost_reg <= thc_pkg::ST_NOFILL;
                    end
                end
                S_OUT: ov_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    assign out_valid    = ov_reg;
    assign out_status   = ost_reg;
    assign out_was_new  = onew_reg;
    assign out_distinct = 13'(fill_reg);
    assign out_key      = okey_reg;
    assign out_count    = ocnt_reg;

endmodule

// ===== rtl/thc_checker.sv =====
// ----------------------------------------------------------------------------
// thc_checker
// port-level checks of the triple hash counter
// ----------------------------------------------------------------------------
`include "triple_hash_counter_macros.svh"

module thc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [39:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata
);

    // a result held back keeps its value
    `THC_ASSERT_NEXT(a_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    // new entry always reports ok with count one
    `THC_ASSERT_IMP(a_new, aclk, aresetn, m_axis_tvalid && m_axis_tdata[2],
        m_axis_tdata[1:0] == thc_pkg::ST_OK && m_axis_tdata[71:40] == 32'd1)
    // status code three never shows
    `THC_ASSERT_IMP(a_status, aclk, aresetn, m_axis_tvalid, m_axis_tdata[1:0] != thc_pkg::ST_UNUSED)
    // fill level never beyond the entry store
    `THC_ASSERT_IMP(a_fill, aclk, aresetn, m_axis_tvalid, m_axis_tdata[15:3] <= 13'd4096)

endmodule

bind triple_hash_counter thc_checker u_thc_checker (.*);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// drives add, read, clear and unused-op requests into the triple hash counter with
// random idling on both channels and checks every response against a
// behavioural copy of the chained hash table
// ----------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT = 2000000;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;

    triple_hash_counter uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  ci;
        logic [7:0]  cj;
        logic [7:0]  ck;
        logic [11:0] idx;
    } request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        was_new;
        logic [12:0] distinct;
        logic [7:0]  oi;
        logic [7:0]  oj;
        logic [7:0]  ok;
        logic [31:0] count;
    } response_t;

    // table copy
    logic [12:0] head_idx   [thc_pkg::BUCKETS];
    logic        head_ok    [thc_pkg::BUCKETS];
    logic [23:0] key_store  [thc_pkg::ENTRIES];
    logic [31:0] count_store[thc_pkg::ENTRIES];
    logic [12:0] next_idx   [thc_pkg::ENTRIES];
    logic        next_ok    [thc_pkg::ENTRIES];
    int unsigned fill;

    request_t  pending_q[$];
    response_t awaited_q[$];
    int        errors;
    int        cycles;
    logic      quiet;
    logic      hold_send;
    logic      s_taken;
    int        s_gap, m_gap;
    int        n_add, n_read, n_clear, n_full, n_resp;

    // clock
    always begin
        aclk = 1'b1; #10;
        aclk = 1'b0; #10;
    end

    function automatic logic [7:0] bucket_for(logic [7:0] i, logic [7:0] j, logic [7:0] k);
        logic [31:0] x;
        logic [11:0] h;
        x = (32'(i) + (32'(j) << 4) + (32'(k) << 8)) * 32'h983F69B1;
        h = x[23:12];
        return 8'(h % thc_pkg::BUCKETS);
    endfunction

    // predict the response of one request and update the table copy
    function automatic response_t count_triple(request_t r);
        response_t   res;
        logic [23:0] key;
        logic [7:0]  b;
        logic        have, found;
        int unsigned p, steps, n;
        res = '0;
        if (r.op == thc_pkg::OP_ADD) begin
            key = {r.ck, r.cj, r.ci};
            b = bucket_for(r.ci, r.cj, r.ck);
            have = head_ok[b];
            p = head_idx[b];
            steps = 0;
            found = 1'b0;
            res.oi = r.ci; res.oj = r.cj; res.ok = r.ck;
            while (have && p < fill && p < thc_pkg::ENTRIES && steps < fill) begin
                if (key_store[p] == key) begin
                    found = 1'b1;
                    break;
                end
                have = next_ok[p];
                p = next_idx[p];
                steps++;
            end
            if (found) begin
                if (count_store[p] != 32'hFFFF_FFFF) count_store[p] = count_store[p] + 1;
                res.count = count_store[p];
            end else if (fill >= thc_pkg::ENTRIES) begin
                res.status = thc_pkg::ST_FULL;
            end else begin
                n = fill;
                key_store[n] = key;
                count_store[n] = 1;
                next_idx[n] = head_idx[b];
                next_ok[n] = head_ok[b];
                head_idx[b] = 13'(n);
                head_ok[b] = 1'b1;
                fill = n + 1;
                res.was_new = 1'b1;
                res.count = 1;
            end
        end else if (r.op == thc_pkg::OP_READ) begin
            if (r.idx < fill) begin
                res.oi = key_store[r.idx][7:0];
                res.oj = key_store[r.idx][15:8];
                res.ok = key_store[r.idx][23:16];
                res.count = count_store[r.idx];
            end else begin
                res.status = thc_pkg::ST_NOFILL;
            end
        end else if (r.op == thc_pkg::OP_CLEAR) begin
            for (int q = 0; q < thc_pkg::BUCKETS; q++) begin
                head_ok[q] = 1'b0;
                head_idx[q] = '0;
            end
            fill = 0;
        end
        res.distinct = 13'(fill);
        return res;
    endfunction

    // request taken at the rising edge
    always @(posedge aclk) begin
        s_taken <= aresetn && s_axis_tvalid && s_axis_tready;
    end

    // driver
    always @(negedge aclk) begin
        request_t r;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_taken) begin
            if (s_gap > 0) begin
                s_gap <= s_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (!quiet && $urandom_range(9) == 0) begin
                s_gap <= $urandom_range(5, 1) - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_q.size() > 0 && !hold_send) begin
                r = pending_q.pop_front();
                s_axis_tdata <= {2'b00, r.idx, r.ck, r.cj, r.ci, r.op};
                s_axis_tvalid <= 1'b1;
                awaited_q.push_back(count_triple(r));
                case (r.op)
                    thc_pkg::OP_ADD:   n_add++;
                    thc_pkg::OP_READ:  n_read++;
                    thc_pkg::OP_CLEAR: n_clear++;
                    default:  ;
                endcase
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver stall
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (m_gap > 0) begin
            m_gap <= m_gap - 1;
            m_axis_tready <= 1'b0;
        end else if (!quiet && $urandom_range(7) == 0) begin
            m_gap <= $urandom_range(5, 1) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // monitor
    always @(posedge aclk) begin
        response_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = '{status: m_axis_tdata[1:0], was_new: m_axis_tdata[2],
                    distinct: m_axis_tdata[15:3], oi: m_axis_tdata[23:16],
                    oj: m_axis_tdata[31:24], ok: m_axis_tdata[39:32],
                    count: m_axis_tdata[71:40]};
            n_resp++;
            if (awaited_q.size() == 0) begin
                $error("response with no request outstanding");
                errors++;
            end else begin
                want = awaited_q.pop_front();
                if (got.status == thc_pkg::ST_FULL) n_full++;
                if (got.status != want.status) begin
                    $error("status expected %0d actual %0d", want.status, got.status);
                    errors++;
                end
                if (got.was_new != want.was_new) begin
                    $error("was_new expected %0d actual %0d", want.was_new, got.was_new);
                    errors++;
                end
                if (got.distinct != want.distinct) begin
                    $error("distinct_count expected %0d actual %0d",
                           want.distinct, got.distinct);
                    errors++;
                end
                if (got.oi != want.oi) begin
                    $error("out_i expected %0d actual %0d", want.oi, got.oi);
                    errors++;
                end
                if (got.oj != want.oj) begin
                    $error("out_j expected %0d actual %0d", want.oj, got.oj);
                    errors++;
                end
                if (got.ok != want.ok) begin
                    $error("out_k expected %0d actual %0d", want.ok, got.ok);
                    errors++;
                end
                if (got.count != want.count) begin
                    $error("out_count expected %0d actual %0d", want.count, got.count);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    task automatic push_req(logic [1:0] op, logic [7:0] i, logic [7:0] j,
                            logic [7:0] k, logic [11:0] idx);
        pending_q.push_back('{op: op, ci: i, cj: j, ck: k, idx: idx});
    endtask

    // wait until everything queued has been answered
    task automatic drain();
        while (pending_q.size() > 0 || awaited_q.size() > 0) @(posedge aclk);
    endtask

    // rough read range so most reads land on filled entries
    function automatic int fill_guess(int n);
        return (n < 40) ? 40 : n;
    endfunction

    initial begin
        logic [7:0] pool_i[16], pool_j[16], pool_k[16];
        int         sel;
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        s_taken = 1'b0;
        errors = 0; cycles = 0; quiet = 1'b0; hold_send = 1'b0;
        s_gap = 0; m_gap = 0;
        n_add = 0; n_read = 0; n_clear = 0; n_full = 0; n_resp = 0;
        fill = 0;
        for (int q = 0; q < thc_pkg::BUCKETS; q++) begin
            head_ok[q] = 1'b0; head_idx[q] = '0;
        end
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: extremes, repeats, reads beyond fill, unused op, clear
        push_req(thc_pkg::OP_READ, 8'h00, 8'h00, 8'h00, 12'd0);
        push_req(thc_pkg::OP_ADD, 8'h00, 8'h00, 8'h00, 12'd0);
        push_req(thc_pkg::OP_ADD, 8'hFF, 8'hFF, 8'hFF, 12'hFFF);
        push_req(thc_pkg::OP_ADD, 8'h00, 8'h00, 8'h00, 12'd0);
        push_req(thc_pkg::OP_ADD, 8'hFF, 8'h00, 8'hFF, 12'd0);
        push_req(thc_pkg::OP_ADD, 8'h00, 8'hFF, 8'h00, 12'd0);
        push_req(thc_pkg::OP_ADD, 8'h10, 8'h01, 8'h00, 12'd0);
        push_req(thc_pkg::OP_ADD, 8'h00, 8'h01, 8'h00, 12'd0);
        push_req(thc_pkg::OP_READ, 8'hFF, 8'hFF, 8'hFF, 12'd0);
        push_req(thc_pkg::OP_READ, 8'h00, 8'h00, 8'h00, 12'd5);
        push_req(thc_pkg::OP_READ, 8'h00, 8'h00, 8'h00, 12'd6);
        push_req(thc_pkg::OP_READ, 8'h00, 8'h00, 8'h00, 12'hFFF);
        push_req(thc_pkg::OP_NOP, 8'hAA, 8'h55, 8'hAA, 12'hAAA);
        push_req(thc_pkg::OP_CLEAR, 8'h00, 8'h00, 8'h00, 12'd0);
        push_req(thc_pkg::OP_READ, 8'h00, 8'h00, 8'h00, 12'd0);
        push_req(thc_pkg::OP_ADD, 8'h12, 8'h34, 8'h56, 12'd0);
        push_req(thc_pkg::OP_READ, 8'h00, 8'h00, 8'h00, 12'd0);

        // wait until all responses have come back
        drain();
        hold_send = 1'b0;

        // random: mostly adds, many from a small pool, so chains and repeats build up
        for (int q = 0; q < 16; q++) begin
            pool_i[q] = 8'($urandom); pool_j[q] = 8'($urandom); pool_k[q] = 8'($urandom);
        end
        for (int n = 0; n < 880; n++) begin
            sel = $urandom_range(99);
            if (sel < 40)
                push_req(thc_pkg::OP_ADD, pool_i[sel % 16], pool_j[sel % 16],
                         pool_k[sel % 16], 12'($urandom));
            else if (sel < 70)
                push_req(thc_pkg::OP_ADD, 8'($urandom), 8'($urandom), 8'($urandom),
                         12'($urandom));
            else if (sel < 92)
                push_req(thc_pkg::OP_READ, 8'($urandom), 8'($urandom), 8'($urandom),
                         ($urandom_range(3) == 0) ? 12'($urandom)
                                                  : 12'($urandom_range(fill_guess(n))));
            else if (sel < 97)
                push_req(thc_pkg::OP_NOP, 8'($urandom), 8'($urandom), 8'($urandom),
                         12'($urandom));
            else
                push_req(thc_pkg::OP_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom),
                         12'($urandom));
        end

        // last part of the run goes without idling
        wait (pending_q.size() < 280);
        quiet = 1'b1;

        drain();
        repeat (40) @(posedge aclk);
        $display("requests: %0d adds, %0d reads, %0d clears; %0d responses, %0d table full",
                 n_add, n_read, n_clear, n_resp, n_full);
        if (errors == 0 && awaited_q.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/thc_pkg.sv
rtl/thc_ram.sv
rtl/thc_front.sv
rtl/thc_back.sv
rtl/triple_hash_counter.sv
rtl/thc_checker.sv
tb/testbench.sv
